[hdl/lvn_pkg.sv]
// ============================================================================
// lvn_pkg: shared types and constants for the 3D lattice value noise core
// Widths, table select codes and the queue entry type.
// ============================================================================
package lvn_pkg;

	localparam int TableDepth   = 256;
	localparam int IdxW         = $clog2(TableDepth);
	localparam int FracW        = 16;
	localparam int ValW         = 16;
	localparam int PermW        = 8;
	localparam int PointW       = 32;
	localparam int QueueDepth   = 4;
	localparam int QueuePtrW    = $clog2(QueueDepth);

	typedef enum logic [1:0] {
		SEL_VALUE  = 2'd0,
		SEL_PERM_X = 2'd1,
		SEL_PERM_Y = 2'd2,
		SEL_PERM_Z = 2'd3
	} table_sel_t;

	typedef enum logic {
		CMD_WRITE  = 1'b0,
		CMD_SAMPLE = 1'b1
	} command_t;

	// One queued sample: lattice cell and raw fraction per axis.
	typedef struct packed {
		logic [IdxW-1:0]  cell_x;
		logic [IdxW-1:0]  cell_y;
		logic [IdxW-1:0]  cell_z;
		logic [FracW-1:0] frac_x;
		logic [FracW-1:0] frac_y;
		logic [FracW-1:0] frac_z;
	} sample_t;

	// Table write broadcast from the front end to the table copies.
	typedef struct packed {
		logic             en;
		table_sel_t       sel;
		logic [IdxW-1:0]  idx;
		logic [ValW-1:0]  data;
	} table_wr_t;

endpackage

[hdl/lvn_if.sv]
// ============================================================================
// lvn_in_if / lvn_out_if: valid/ready channels of the noise core
// Input carries the command item, output carries the noise result.
// ============================================================================
interface lvn_in_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [1:0]  table_select;
	logic [7:0]  table_index;
	logic [15:0] table_data;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	logic signed [31:0] point_z;

	modport source (output valid, command, table_select, table_index, table_data,
		point_x, point_y, point_z, input ready);
	modport sink (input valid, command, table_select, table_index, table_data,
		point_x, point_y, point_z, output ready);
endinterface

interface lvn_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] noise_value;

	modport source (output valid, noise_value, input ready);
	modport sink (input valid, noise_value, output ready);
endinterface

[hdl/lattice_value_noise_3d_core.sv]
// ============================================================================
// lattice_value_noise_3d_core: 3D lattice value noise, trilinear smoothstep
// Front classifies items, queue decouples, back looks up and blends.
// ============================================================================
//  channel | dir | payload
//  in_ch   | in  | command, table_select, table_index, table_data, point_x/y/z
//  out_ch  | out | noise_value
//
//  One sample item per cycle sustained while out_ch is ready; a result passes
//  the queue slot, perm read + square, value read + fade, x/y/z blends and
//  output reg.
//  A write is taken only once the queue and the perm read stage are empty, so
//  a write right behind a sample waits for both to drain; it lands at its
//  accept edge and gives no result.
//  arst_n clears control only; tables are undefined until written.
//  A stall on out_ch freezes the whole back pipeline; the 4-entry queue then
//  fills and in_ch.ready drops for samples.
module lattice_value_noise_3d_core (
	input  logic clk,
	input  logic arst_n,
	lvn_in_if.sink    in_ch,
	lvn_out_if.source out_ch
);
	logic               q_full, q_push, q_pop, q_nempty;
	logic               rd_busy, wr_hold;
	lvn_pkg::sample_t   q_in, q_out;
	lvn_pkg::table_wr_t wr;

	// Table writes must not overtake samples that still read the tables.
	assign wr_hold = q_nempty || rd_busy;

	lvn_front u_front (
		.in_ch   (in_ch),
		.q_full  (q_full),
		.wr_hold (wr_hold),
		.q_push  (q_push),
		.q_data  (q_in),
		.wr      (wr)
	);

	lvn_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_nempty),
		.pop_data  (q_out)
	);

	lvn_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.q_valid (q_nempty),
		.q_data  (q_out),
		.q_pop   (q_pop),
		.rd_busy (rd_busy),
		.out_ch  (out_ch)
	);
endmodule

[hdl/lvn_front.sv]
// ============================================================================
// lvn_front: command classifier
// Splits write items into table writes and samples into queue entries.
// ============================================================================
module lvn_front (
	lvn_in_if.sink               in_ch,
	input  logic                 q_full,
	input  logic                 wr_hold,
	output logic                 q_push,
	output lvn_pkg::sample_t     q_data,
	output lvn_pkg::table_wr_t   wr
);
	logic acc;

	// Writes wait until no earlier sample still has table reads ahead of it;
	// samples wait for a free slot.
	assign in_ch.ready = (in_ch.command == lvn_pkg::CMD_WRITE) ? !wr_hold : !q_full;
	assign acc         = in_ch.valid && in_ch.ready;

	assign q_push = acc && (in_ch.command == lvn_pkg::CMD_SAMPLE);
	always_comb begin
		q_data.cell_x = in_ch.point_x[lvn_pkg::FracW +: lvn_pkg::IdxW];
		q_data.cell_y = in_ch.point_y[lvn_pkg::FracW +: lvn_pkg::IdxW];
		q_data.cell_z = in_ch.point_z[lvn_pkg::FracW +: lvn_pkg::IdxW];
		q_data.frac_x = in_ch.point_x[lvn_pkg::FracW-1:0];
		q_data.frac_y = in_ch.point_y[lvn_pkg::FracW-1:0];
		q_data.frac_z = in_ch.point_z[lvn_pkg::FracW-1:0];
	end

	always_comb begin
		wr.en   = acc && (in_ch.command == lvn_pkg::CMD_WRITE);
		wr.sel  = lvn_pkg::table_sel_t'(in_ch.table_select);
		wr.idx  = in_ch.table_index[lvn_pkg::IdxW-1:0];
		wr.data = in_ch.table_data;
	end
endmodule

[hdl/lvn_queue.sv]
// ============================================================================
// lvn_queue: small FIFO between front and back
// ============================================================================
module lvn_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  lvn_pkg::sample_t     push_data,
	output logic                 full,
	input  logic                 pop,
	output logic                 not_empty,
	output lvn_pkg::sample_t     pop_data
);
	lvn_pkg::sample_t mem_q [lvn_pkg::QueueDepth];
	logic [lvn_pkg::QueuePtrW-1:0] wptr_q, rptr_q;
	logic [lvn_pkg::QueuePtrW:0]   count_q;

	assign full      = (count_q == (lvn_pkg::QueuePtrW+1)'(lvn_pkg::QueueDepth));
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (pop)  rptr_q <= rptr_q + 1'b1;
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule

[hdl/lvn_back.sv]
// ============================================================================
// lvn_back: table lookup, fade and trilinear blend pipeline
// Perm and value tables are replicated so eight corners read per cycle.
// ============================================================================
module lvn_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lvn_pkg::table_wr_t   wr,
	input  logic                 q_valid,
	input  lvn_pkg::sample_t     q_data,
	output logic                 q_pop,
	output logic                 rd_busy,
	lvn_out_if.source            out_ch
);
	localparam int F  = lvn_pkg::FracW;
	localparam int IW = lvn_pkg::IdxW;
	localparam int VW = lvn_pkg::ValW;
	localparam int PW = lvn_pkg::PermW;

	// Perm copies: two reads each (cell, cell+1); value copies: one per corner.
	logic [PW-1:0] px_q [2][lvn_pkg::TableDepth];
	logic [PW-1:0] py_q [2][lvn_pkg::TableDepth];
	logic [PW-1:0] pz_q [2][lvn_pkg::TableDepth];
	logic [VW-1:0] val_q [8][lvn_pkg::TableDepth];

	logic          adv;
	logic [4:0]    v_q;     // valid bits of stages 1..5
	logic          out_v_q;
	logic [VW-1:0] out_d_q;

	// All stages move together; they freeze while a result waits on out_ch.
	assign adv     = !out_v_q || out_ch.ready;
	assign q_pop   = q_valid && adv;
	// Stage 1 holds perm entries whose value read is still ahead.
	assign rd_busy = v_q[0];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			for (int k = 0; k < 2; k++) begin
				if (wr.sel == lvn_pkg::SEL_PERM_X) px_q[k][wr.idx] <= wr.data[PW-1:0];
				if (wr.sel == lvn_pkg::SEL_PERM_Y) py_q[k][wr.idx] <= wr.data[PW-1:0];
				if (wr.sel == lvn_pkg::SEL_PERM_Z) pz_q[k][wr.idx] <= wr.data[PW-1:0];
			end
			for (int k = 0; k < 8; k++)
				if (wr.sel == lvn_pkg::SEL_VALUE) val_q[k][wr.idx] <= wr.data;
		end
	end

	// ---- stage 1: perm reads, fade square
	logic [PW-1:0] hx_s1 [2], hy_s1 [2], hz_s1 [2];
	logic [F-1:0]  fx_s1, fy_s1, fz_s1;
	logic [F-1:0]  sq_s1 [3];
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 2; k++) begin
				hx_s1[k] <= px_q[k][q_data.cell_x + IW'(k)];
				hy_s1[k] <= py_q[k][q_data.cell_y + IW'(k)];
				hz_s1[k] <= pz_q[k][q_data.cell_z + IW'(k)];
			end
			fx_s1 <= q_data.frac_x;
			fy_s1 <= q_data.frac_y;
			fz_s1 <= q_data.frac_z;
			sq_s1[0] <= F'((2*F)'(q_data.frac_x) * (2*F)'(q_data.frac_x) >> F);
			sq_s1[1] <= F'((2*F)'(q_data.frac_y) * (2*F)'(q_data.frac_y) >> F);
			sq_s1[2] <= F'((2*F)'(q_data.frac_z) * (2*F)'(q_data.frac_z) >> F);
		end
	end

	// ---- stage 2: value reads, fade second multiply
	logic [VW-1:0] c_s2 [8];
	logic [F-1:0]  t_s2 [3];
	logic [F-1:0]  f_s1 [3];
	assign f_s1[0] = fx_s1;
	assign f_s1[1] = fy_s1;
	assign f_s1[2] = fz_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 8; k++)
				c_s2[k] <= val_q[k][IW'(hx_s1[k[2]] ^ hy_s1[k[1]] ^ hz_s1[k[0]])];
			for (int a = 0; a < 3; a++)
				t_s2[a] <= F'(((2*F+2)'(sq_s1[a]) * ((2*F+2)'(3) << F) - (2*F+2)'(sq_s1[a])
					* ((2*F+2)'(f_s1[a]) << 1)) >> F);
		end
	end

	// ---- stages 3-5: x, y, then z blend, one axis per stage
	function automatic logic [VW+F:0] bl(input logic [VW-1:0] a, input logic [VW-1:0] b,
		input logic [F-1:0] t);
		logic [F:0] omt;
		begin
			omt = (F+1)'(1) << F;
			omt = omt - (F+1)'(t);
			bl  = (VW+F+1)'(a) * (VW+F+1)'(omt) + (VW+F+1)'(b) * (VW+F+1)'(t);
		end
	endfunction

	logic [VW+F:0] ex_s3 [4];
	logic [F-1:0]  ty_s3, tz_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 4; k++) ex_s3[k] <= bl(c_s2[k], c_s2[k+4], t_s2[0]);
			ty_s3 <= t_s2[1];
			tz_s3 <= t_s2[2];
		end
	end
	logic [VW+F:0] gy_s4 [2];
	logic [F-1:0]  tz_s4;
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 2; k++)
				gy_s4[k] <= bl(VW'(ex_s3[k] >> F), VW'(ex_s3[k+2] >> F), ty_s3);
			tz_s4 <= tz_s3;
		end
	end
	logic [VW+F:0] r_s5;
	always_ff @(posedge clk) begin
		if (adv) r_s5 <= bl(VW'(gy_s4[0] >> F), VW'(gy_s4[1] >> F), tz_s4);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q     <= '0;
			out_v_q <= 1'b0;
		end else if (adv) begin
			v_q     <= {v_q[3:0], q_pop};
			out_v_q <= v_q[4];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) out_d_q <= VW'(r_s5 >> F);
	end

	assign out_ch.valid       = out_v_q;
	assign out_ch.noise_value = out_d_q;
endmodule

[verif/lvn_tb_if.sv]
`timescale 1ns / 1ps
// ============================================================================
// lvn_tb_if: testbench-side notes for the noise core channels
// The channel interfaces come from the design; this file holds none of its own.
// ============================================================================
package lvn_tb_pkg;

	// One input item as the driver sees it.
	typedef struct {
		lvn_pkg::command_t   cmd;
		lvn_pkg::table_sel_t sel;
		logic [7:0]  idx;
		logic [15:0] data;
		logic [31:0] px;
		logic [31:0] py;
		logic [31:0] pz;
	} noise_item_t;
endpackage

[verif/tb_lattice_value_noise_3d_core.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_lattice_value_noise_3d_core: self-checking bench for the noise core
// Loads the table entries that samples can reach, then samples points.
// Directed edge points come first, then random traffic. Table rewrites are
// mixed in, and both sides idle at random. A local fixed-point model predicts
// each noise value.
// ============================================================================
module tb_lattice_value_noise_3d_core;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	lvn_in_if  in_ch();
	lvn_out_if out_ch();

	lattice_value_noise_3d_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Local copy of the tables.
	logic [15:0] val_tbl [256];
	logic [7:0]  prm_x [256];
	logic [7:0]  prm_y [256];
	logic [7:0]  prm_z [256];

	lvn_tb_pkg::noise_item_t pending_items[$];
	logic [15:0] expected_noise[$];
	int mismatches = 0;
	bit stim_done = 0;

	function automatic logic [63:0] smooth_fade(logic [63:0] f);
		logic [63:0] q;
		q = (f * f) >> 16;
		return (q * ((64'd3 << 16) - 2 * f)) >> 16;
	endfunction

	function automatic logic [63:0] lerp_fix(logic [63:0] a, logic [63:0] b, logic [63:0] t);
		return (a * ((64'd1 << 16) - t) + b * t) >> 16;
	endfunction

	// Predicted noise for a sample point, using the local tables.
	function automatic logic [15:0] noise_at(logic [31:0] px, logic [31:0] py,
			logic [31:0] pz);
		logic [7:0]  cx, cy, cz;
		logic [63:0] fx, fy, fz;
		logic [63:0] crn [2][2][2];
		logic [63:0] ex [2][2];
		logic [63:0] ey [2];
		logic [7:0]  h;
		cx = px[23:16]; cy = py[23:16]; cz = pz[23:16];
		fx = smooth_fade({48'd0, px[15:0]});
		fy = smooth_fade({48'd0, py[15:0]});
		fz = smooth_fade({48'd0, pz[15:0]});
		for (int a = 0; a < 2; a++)
			for (int b = 0; b < 2; b++)
				for (int c = 0; c < 2; c++) begin
					h = prm_x[8'(cx + a)] ^ prm_y[8'(cy + b)] ^ prm_z[8'(cz + c)];
					crn[a][b][c] = {48'd0, val_tbl[h]};
				end
		for (int b = 0; b < 2; b++)
			for (int c = 0; c < 2; c++)
				ex[b][c] = lerp_fix(crn[0][b][c], crn[1][b][c], fx);
		for (int c = 0; c < 2; c++)
			ey[c] = lerp_fix(ex[0][c], ex[1][c], fy);
		return 16'(lerp_fix(ey[0], ey[1], fz));
	endfunction

	function automatic lvn_tb_pkg::noise_item_t write_item(lvn_pkg::table_sel_t s,
			logic [7:0] i, logic [15:0] d);
		lvn_tb_pkg::noise_item_t it;
		it.cmd = lvn_pkg::CMD_WRITE; it.sel = s; it.idx = i; it.data = d;
		it.px = $urandom; it.py = $urandom; it.pz = $urandom;
		return it;
	endfunction

	function automatic lvn_tb_pkg::noise_item_t sample_item(logic [31:0] x, logic [31:0] y,
			logic [31:0] z);
		lvn_tb_pkg::noise_item_t it;
		it.cmd = lvn_pkg::CMD_SAMPLE; it.sel = lvn_pkg::table_sel_t'($urandom_range(0, 3));
		it.idx = $urandom; it.data = $urandom;
		it.px = x; it.py = y; it.pz = z;
		return it;
	endfunction

	// Perm entry below 64 with a random upper byte that must be dropped.
	function automatic logic [15:0] perm_data();
		return {8'($urandom), 2'b00, 6'($urandom)};
	endfunction

	// Cell stays inside the loaded perm window, cell+1 too (255 wraps to 0).
	function automatic logic [31:0] rand_point();
		logic [7:0] c;
		c = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 30))
			: 8'($urandom_range(224, 255));
		case ($urandom_range(0, 3))
			0: return {8'($urandom), c, 16'($urandom)};
			1: return {8'($urandom), c, 16'hFFFF};
			2: return {8'($urandom), c, 16'h0000};
			default: return {{8{c[7]}}, c, 16'($urandom)};
		endcase
	endfunction

	// Stimulus: table load, directed points, then random traffic.
	// Perm entries stay below 64, so every hash lands in value entries 0..63;
	// perm entries are loaded for cells 224..255 and 0..31.
	initial begin
		lvn_pkg::table_sel_t s;
		for (int t = 0; t < 4; t++)
			for (int i = 0; i < 256; i++) begin
				s = lvn_pkg::table_sel_t'(t);
				if (s == lvn_pkg::SEL_VALUE) begin
					if (i < 64)
						pending_items.push_back(write_item(s, i[7:0], 16'($urandom)));
				end else if (i < 32 || i >= 224) begin
					pending_items.push_back(write_item(s, i[7:0], perm_data()));
				end
			end
		pending_items.push_back(write_item(lvn_pkg::SEL_VALUE, 8'd0, 16'hFFFF));
		pending_items.push_back(write_item(lvn_pkg::SEL_VALUE, 8'd63, 16'h0000));
		pending_items.push_back(sample_item(32'h0, 32'h0, 32'h0));
		pending_items.push_back(sample_item(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
		pending_items.push_back(sample_item(32'h80000000, 32'h80000000, 32'h80000000));
		pending_items.push_back(sample_item(32'hFFFFFFFF, 32'h0000FFFF, 32'hFFFF0000));
		pending_items.push_back(sample_item(32'h00008000, 32'h00018000, 32'hFFFF8000));
		pending_items.push_back(sample_item(32'h00FF0001, 32'hFF00FFFE, 32'h00FFFFFF));
		pending_items.push_back(sample_item(32'h00010000, 32'h7FFF0000, 32'h80010000));
		pending_items.push_back(write_item(lvn_pkg::SEL_PERM_X, 8'hFF, 16'hFF3F));
		pending_items.push_back(write_item(lvn_pkg::SEL_PERM_Y, 8'h00, 16'h5A00));
		pending_items.push_back(write_item(lvn_pkg::SEL_PERM_Z, 8'hE0, 16'hA525));
		pending_items.push_back(sample_item(32'h00FF4000, 32'hFFFFC000, 32'h001E2000));
		pending_items.push_back(sample_item(32'h55E55555, 32'hAA0AAAAA, 32'h12F45678));
		for (int n = 0; n < 580; n++) begin
			if ($urandom_range(0, 9) < 8)
				pending_items.push_back(sample_item(rand_point(), rand_point(), rand_point()));
			else begin
				s = lvn_pkg::table_sel_t'($urandom_range(0, 3));
				pending_items.push_back(write_item(s, 8'($urandom),
					s == lvn_pkg::SEL_VALUE ? 16'($urandom) : perm_data()));
			end
		end
		stim_done = 1;
	end

	// Reset sequence.
	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Driver: one item at a time, random gap before each.
	int in_gap = 0;
	always @(posedge clk) begin
		lvn_tb_pkg::noise_item_t it;
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.command <= lvn_pkg::CMD_WRITE;
			in_ch.table_select <= lvn_pkg::SEL_VALUE;
			in_ch.table_index <= '0;
			in_ch.table_data <= '0;
			in_ch.point_x <= '0;
			in_ch.point_y <= '0;
			in_ch.point_z <= '0;
		end else begin
			// Model the accept at this edge: tables update, samples predicted.
			if (in_ch.valid && in_ch.ready) begin
				if (in_ch.command == lvn_pkg::CMD_SAMPLE)
					expected_noise.push_back(noise_at(in_ch.point_x, in_ch.point_y,
						in_ch.point_z));
				else
					unique case (lvn_pkg::table_sel_t'(in_ch.table_select))
						lvn_pkg::SEL_VALUE:  val_tbl[in_ch.table_index] = in_ch.table_data;
						lvn_pkg::SEL_PERM_X: prm_x[in_ch.table_index] = in_ch.table_data[7:0];
						lvn_pkg::SEL_PERM_Y: prm_y[in_ch.table_index] = in_ch.table_data[7:0];
						lvn_pkg::SEL_PERM_Z: prm_z[in_ch.table_index] = in_ch.table_data[7:0];
					endcase
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (in_gap > 0) begin
					in_gap <= in_gap - 1;
					in_ch.valid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					it = pending_items.pop_front();
					in_ch.valid <= 1'b1;
					in_ch.command <= it.cmd;
					in_ch.table_select <= it.sel;
					in_ch.table_index <= it.idx;
					in_ch.table_data <= it.data;
					in_ch.point_x <= it.px;
					in_ch.point_y <= it.py;
					in_ch.point_z <= it.pz;
					// Bursts with no gap for about a third of the items.
					in_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: random stalls on the result side, check in order.
	int out_wait = 0;
	always @(posedge clk) begin
		logic [15:0] exp_v;
		int          w;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_noise.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result noise_value=%h", out_ch.noise_value);
				end else begin
					exp_v = expected_noise.pop_front();
					if (out_ch.noise_value !== exp_v) begin
						mismatches++;
						if (mismatches <= 10)
							$display("noise_value exp=%h got=%h", exp_v, out_ch.noise_value);
					end
				end
				// Wait before the next result; zero keeps ready high.
				w = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
				out_ch.ready <= (w == 0);
				out_wait <= (w == 0) ? 0 : w - 1;
			end else if (out_wait > 0) begin
				out_wait <= out_wait - 1;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// End of run: drained, then a wait for any stray result.
	initial begin
		wait (stim_done);
		wait (arst_n);
		@(posedge clk);
		while (pending_items.size() > 0 || in_ch.valid || expected_noise.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0 && expected_noise.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#5ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

[filelist.f]
hdl/lvn_pkg.sv
hdl/lvn_if.sv
hdl/lvn_front.sv
hdl/lvn_queue.sv
hdl/lvn_back.sv
hdl/lattice_value_noise_3d_core.sv
verif/lvn_tb_if.sv
verif/tb_lattice_value_noise_3d_core.sv
